[src/vox_pkg.sv]
// shared types, constants and helpers for the voxel grid accumulator
package vox_pkg;

    localparam int GRID_X = 16;
    localparam int GRID_Y = 16;
    localparam int GRID_Z = 16;
    localparam int STORE_DEPTH = GRID_X * GRID_Y * GRID_Z;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XI_W = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YI_W = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZI_W = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;

    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] ORIGIN_RST = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] SCALE_RST = 32'd524288;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_ORIGIN_X = 3'd0;
    localparam cfg_idx_t REG_ORIGIN_Y = 3'd1;
    localparam cfg_idx_t REG_ORIGIN_Z = 3'd2;
    localparam cfg_idx_t REG_SCALE_X = 3'd3;
    localparam cfg_idx_t REG_SCALE_Y = 3'd4;
    localparam cfg_idx_t REG_SCALE_Z = 3'd5;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic  clr_step;
        logic  capture;
        logic  sub;
        logic  mul;
        logic  chk;
        logic  addr;
        logic  rd;
        logic  wr;
        logic  load_bad;
        logic  load_out;
        axis_t axis;
    } vox_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic req_ok;
        logic chk_ok;
        logic slot_free;
    } vox_stat_t;

    function automatic logic [DATA_W-1:0] grid_size(input axis_t a);
        logic [DATA_W-1:0] s;
        case (a)
            AXIS_X:  s = DATA_W'(GRID_X);
            AXIS_Y:  s = DATA_W'(GRID_Y);
            AXIS_Z:  s = DATA_W'(GRID_Z);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

[src/vox_dp.sv]
// datapath: config registers, shared axis subtract/multiply/compare, store and output register
module vox_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic signed [31:0]       point_x,
    input  logic signed [31:0]       point_y,
    input  logic signed [31:0]       point_z,
    input  logic signed [31:0]       add_value,
    input  logic                     request_ok,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [31:0]       cell_sum,
    output logic                     in_range,
    output logic                     answered,
    input  vox_pkg::vox_cmd_t        cmd,
    output vox_pkg::vox_stat_t       stat
);
    import vox_pkg::*;

    logic [DATA_W-1:0] origin_reg [3];
    logic [DATA_W-1:0] scale_reg [3];
    logic [DATA_W-1:0] pt_reg [3];
    logic [DATA_W-1:0] val_reg;

    logic [DATA_W:0]   d_reg;
    logic [DATA_W-1:0] prod_hi_reg;
    logic              neg_nz_reg;
    logic [XI_W-1:0]   ix_reg;
    logic [YI_W-1:0]   iy_reg;
    logic [ZI_W-1:0]   iz_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] cell_sum_reg;
    logic              in_range_reg;
    logic              answered_reg;

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    logic [DATA_W-1:0]   origin_sel;
    logic [DATA_W-1:0]   scale_sel;
    logic [DATA_W-1:0]   pt_sel;
    logic [DATA_W:0]     d_next;
    logic [2*DATA_W-1:0] prod;
    logic                chk_ok;
    logic [DATA_W:0]     sum_wide;
    logic [DATA_W-1:0]   sum_sat;
    logic [DATA_W-1:0]   addr_wide;
    logic [ADDR_W-1:0]   wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                wr_en;

    always_comb
    begin
        origin_sel = origin_reg[cmd.axis];
        scale_sel  = scale_reg[cmd.axis];
        pt_sel     = pt_reg[cmd.axis];
    end

    assign d_next = {pt_sel[DATA_W-1], pt_sel} - {origin_sel[DATA_W-1], origin_sel};
    assign prod = (2*DATA_W)'(d_reg[DATA_W-1:0]) * (2*DATA_W)'(scale_sel);

    // a negative offset is out unless the scale is zero, which pins the index at 0
    assign chk_ok = !neg_nz_reg && (prod_hi_reg < grid_size(cmd.axis));

    assign sum_wide = {rd_data_reg[DATA_W-1], rd_data_reg} + {val_reg[DATA_W-1], val_reg};

    always_comb
    begin
        if (sum_wide[DATA_W] != sum_wide[DATA_W-1])
        begin
            sum_sat = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[DATA_W-1:0];
        end
    end

    assign addr_wide = DATA_W'(iz_reg) * DATA_W'(GRID_X * GRID_Y)
                     + DATA_W'(iy_reg) * DATA_W'(GRID_X)
                     + DATA_W'(ix_reg);

    assign wr_en   = cmd.clr_step || cmd.wr;
    assign wr_addr = cmd.clr_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_step ? '0 : sum_sat;

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= ORIGIN_RST;
                scale_reg[i]  <= SCALE_RST;
            end
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                    REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                    REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                    REG_SCALE_X:  scale_reg[0] <= cfg_data;
                    REG_SCALE_Y:  scale_reg[1] <= cfg_data;
                    REG_SCALE_Z:  scale_reg[2] <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.wr || cmd.load_bad || cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            val_reg   <= add_value;
        end
        if (cmd.sub)
        begin
            d_reg <= d_next;
        end
        if (cmd.mul)
        begin
            prod_hi_reg <= prod[2*DATA_W-1:DATA_W];
            neg_nz_reg  <= d_reg[DATA_W] && (scale_sel != '0);
        end
        if (cmd.chk)
        begin
            case (cmd.axis)
                AXIS_X:  ix_reg <= prod_hi_reg[XI_W-1:0];
                AXIS_Y:  iy_reg <= prod_hi_reg[YI_W-1:0];
                AXIS_Z:  iz_reg <= prod_hi_reg[ZI_W-1:0];
                default: ;
            endcase
        end
        if (cmd.addr)
        begin
            addr_reg <= addr_wide[ADDR_W-1:0];
        end
        if (cmd.wr)
        begin
            cell_sum_reg <= sum_sat;
            in_range_reg <= 1'b1;
            answered_reg <= 1'b1;
        end
        else if (cmd.load_out)
        begin
            cell_sum_reg <= '0;
            in_range_reg <= 1'b0;
            answered_reg <= 1'b1;
        end
        else if (cmd.load_bad)
        begin
            cell_sum_reg <= val_reg;
            in_range_reg <= 1'b0;
            answered_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.clr_last  = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
        stat.req_ok    = request_ok;
        stat.chk_ok    = chk_ok;
        stat.slot_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign cell_sum  = cell_sum_reg;
    assign in_range  = in_range_reg;
    assign answered  = answered_reg;

endmodule

[src/vox_ctrl.sv]
// controller: sequences the clearing pass and the per-item axis, read and write steps
module vox_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output vox_pkg::vox_cmd_t  cmd,
    input  vox_pkg::vox_stat_t stat
);
    import vox_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUB,
        ST_MUL,
        ST_CHK,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_BAD,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    axis_t  axis_reg;
    axis_t  axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                axis_next   = AXIS_X;
                if (in_valid)
                begin
                    state_next = stat.req_ok ? ST_SUB : ST_BAD;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.chk = 1'b1;
                if (!stat.chk_ok)
                begin
                    state_next = ST_OUT;
                end
                else if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_ADDR;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_SUB;
                end
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // write and result load happen together, once the output slot is free
                if (stat.slot_free)
                begin
                    cmd.wr     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/voxel_grid_accumulator.sv]
// in-range item: result registered at the write step, then the next item is taken
// out-of-range item: loaded after the failing axis compare; malformed item: no axis steps
// each axis takes three steps (subtract, 32x32 multiply, compare) on one shared unit, then
// an address, a store read and a saturating write step, which waits for a free output slot
// after reset the store is cleared one entry a cycle (4096 entries); no item is taken meanwhile,
// configuration writes are taken at any time
module voxel_grid_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] add_value,
    input  logic               request_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cell_sum,
    output logic               in_range,
    output logic               answered
);
    import vox_pkg::*;

    vox_cmd_t  cmd;
    vox_stat_t stat;

    assign cfg_ready = 1'b1;

    vox_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vox_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .add_value  (add_value),
        .request_ok (request_ok),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .cell_sum   (cell_sum),
        .in_range   (in_range),
        .answered   (answered),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

[src/vox_checker.sv]
// port-level checks for the voxel grid accumulator and their binding
module vox_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] cell_sum,
    input logic               in_range,
    input logic               answered
);

    // a result waiting for the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_sum)
            && $stable(in_range) && $stable(answered))
        else $error("result changed while stalled");

    // one item at a time: the item slot closes right after an item is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while another is in progress");

    a_range_answered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> answered)
        else $error("in-range result not marked answered");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && answered && !in_range |-> cell_sum == 32'sd0)
        else $error("out-of-range result carries a nonzero sum");

endmodule

bind voxel_grid_accumulator vox_checker u_vox_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_sum  (cell_sum),
    .in_range  (in_range),
    .answered  (answered)
);
